/* sv/gdate_pkg.sv */
`timescale 1ns / 1ps

package gdate_pkg;

  // Low COUNT_BITS bits of day_count are used (range 8 to 24).
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned R400_W  = 9;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [R400_W-1:0]  R400_MAX  = R400_W'(399);
  localparam logic [YEAR_W-1:0]  CYCLE_400 = YEAR_W'(400);

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  localparam logic [DAY_W-1:0] MONTH_LEN_NORM [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [DAY_W-1:0] MONTH_LEN_LEAP [12] = '{
    5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Leap test from the year modulo 400.
  function automatic logic leap_of(input logic [R400_W-1:0] r400);
    return (r400[1:0] == 2'b00) && (r400 != R400_W'(100)) &&
           (r400 != R400_W'(200)) && (r400 != R400_W'(300));
  endfunction

  // Month length; zero for a month code outside 1..12.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [3:0] idx;
    idx = 4'(month - MONTH_JAN);
    if (month == '0 || month > MONTH_DEC) begin
      return '0;
    end
    return leap ? MONTH_LEN_LEAP[idx] : MONTH_LEN_NORM[idx];
  endfunction

  typedef struct packed {
    logic                  dir;    // 1: walk backward
    logic [YEAR_W-1:0]     year;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
    logic [COUNT_BITS-1:0] rem;
    logic [R400_W-1:0]     r400;
  } step_req_t;

  typedef struct packed {
    logic                  done;
    logic                  ovf;
    logic [YEAR_W-1:0]     year;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
    logic [COUNT_BITS-1:0] rem;
    logic [R400_W-1:0]     r400;
  } step_rsp_t;

endpackage

/* sv/gdate_step.sv */
`timescale 1ns / 1ps

// One month step of the date walk.
module gdate_step (
  input  gdate_pkg::step_req_t req_i,
  output gdate_pkg::step_rsp_t rsp_o
);

  logic [gdate_pkg::DAY_W-1:0]    len_cur;
  logic [gdate_pkg::DAY_W-1:0]    room;
  logic [gdate_pkg::DAY_W:0]      room_p1;
  logic                           wrap_fwd;
  logic                           wrap_bwd;
  logic [gdate_pkg::R400_W-1:0]   r400_inc;
  logic [gdate_pkg::R400_W-1:0]   r400_dec;
  logic [gdate_pkg::MONTH_W-1:0]  month_prev;

  assign len_cur  = gdate_pkg::month_len(req_i.month, gdate_pkg::leap_of(req_i.r400));
  assign room     = len_cur - req_i.day;
  assign room_p1  = {1'b0, room} + 6'd1;
  assign wrap_fwd = (req_i.month == gdate_pkg::MONTH_DEC);
  assign wrap_bwd = (req_i.month == gdate_pkg::MONTH_JAN);
  assign r400_inc = (req_i.r400 == gdate_pkg::R400_MAX) ? '0 : req_i.r400 + 9'd1;
  assign r400_dec = (req_i.r400 == '0) ? gdate_pkg::R400_MAX : req_i.r400 - 9'd1;
  assign month_prev = wrap_bwd ? gdate_pkg::MONTH_DEC : req_i.month - 4'd1;

  always_comb begin
    rsp_o.done  = 1'b0;
    rsp_o.ovf   = 1'b0;
    rsp_o.year  = req_i.year;
    rsp_o.month = req_i.month;
    rsp_o.day   = req_i.day;
    rsp_o.rem   = req_i.rem;
    rsp_o.r400  = req_i.r400;
    if (!req_i.dir) begin
      if (req_i.rem <= gdate_pkg::COUNT_BITS'(room)) begin
        rsp_o.done = 1'b1;
        rsp_o.day  = req_i.day + req_i.rem[gdate_pkg::DAY_W-1:0];
      end else if (wrap_fwd && req_i.year == gdate_pkg::YEAR_MAX) begin
        rsp_o.ovf = 1'b1;
      end else begin
        // jump to the first of the next month
        rsp_o.rem   = req_i.rem - gdate_pkg::COUNT_BITS'(room_p1);
        rsp_o.day   = gdate_pkg::DAY_W'(1);
        rsp_o.month = wrap_fwd ? gdate_pkg::MONTH_JAN : req_i.month + 4'd1;
        if (wrap_fwd) begin
          rsp_o.year = req_i.year + 14'd1;
          rsp_o.r400 = r400_inc;
        end
      end
    end else begin
      if (req_i.rem < gdate_pkg::COUNT_BITS'(req_i.day)) begin
        rsp_o.done = 1'b1;
        rsp_o.day  = req_i.day - req_i.rem[gdate_pkg::DAY_W-1:0];
      end else if (wrap_bwd && req_i.year == gdate_pkg::YEAR_MIN) begin
        rsp_o.ovf = 1'b1;
      end else begin
        // jump to the last day of the previous month
        rsp_o.rem   = req_i.rem - gdate_pkg::COUNT_BITS'(req_i.day);
        rsp_o.month = month_prev;
        if (wrap_bwd) begin
          rsp_o.year = req_i.year - 14'd1;
          rsp_o.r400 = r400_dec;
        end
        rsp_o.day = gdate_pkg::month_len(month_prev,
                      gdate_pkg::leap_of(wrap_bwd ? r400_dec : req_i.r400));
      end
    end
  end

endmodule

/* sv/gregorian_date_add_subtract_days.sv */
`timescale 1ns / 1ps

// Gregorian date plus or minus a day count.
// Input stream: one request per date. tuser carries action (0 forward,
// 1 backward); tdata carries start year, month, day and day count.
// Output stream: one result per request. tdata carries the result date,
// tuser the status (ok, invalid start date, result outside 1..9999).
// A request crosses M month boundaries (up to about 2154 for a 16-bit
// count) and passes through these steps:
//   - reducing the year modulo 400 by repeated subtraction
//   - checking the day against the month length
//   - one month per cycle in the walk through the step unit
//   - presenting the result until the receiver takes it
// A start date with a bad year, month or day code goes straight to output.
// s_axis_tready_o is high only while the block is idle, so one request is
// in flight at a time. The result is held in registers and stays stable
// until the receiver takes it; a stalled receiver simply holds the block.
// Reset returns the sequencer to idle and drops any result not yet taken.
module gregorian_date_add_subtract_days (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [38:23] day_count, [39] zero
  input  logic [39:0] s_axis_tdata_i,
  // [0] action
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [13:0] result_year, [17:14] result_month, [22:18] result_day, [23] zero
  output logic [23:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam int unsigned CB   = gdate_pkg::COUNT_BITS;
  localparam int unsigned ExtW = (CB > 16) ? CB : 16;

  logic [2:0] state_q, state_d;

  logic                          dir_q;
  logic [gdate_pkg::YEAR_W-1:0]  year_q, year_d;
  logic [gdate_pkg::MONTH_W-1:0] month_q, month_d;
  logic [gdate_pkg::DAY_W-1:0]   day_q, day_d;
  logic [CB-1:0]                 rem_q, rem_d;
  logic [gdate_pkg::R400_W-1:0]  r400_q, r400_d;
  logic [gdate_pkg::YEAR_W-1:0]  yrem_q, yrem_d;   // year being reduced mod 400
  logic [1:0]                    status_q, status_d;

  logic [gdate_pkg::YEAR_W-1:0]  in_year;
  logic [gdate_pkg::MONTH_W-1:0] in_month;
  logic [gdate_pkg::DAY_W-1:0]   in_day;
  logic [ExtW-1:0]               in_count_ext;
  logic                          in_bad;
  logic                          in_fire;

  gdate_pkg::step_req_t step_req;
  gdate_pkg::step_rsp_t step_rsp;

  assign in_year      = s_axis_tdata_i[13:0];
  assign in_month     = s_axis_tdata_i[17:14];
  assign in_day       = s_axis_tdata_i[22:18];
  assign in_count_ext = ExtW'(s_axis_tdata_i[38:23]);

  assign in_bad = !(in_year inside {[1:9999]}) || !(in_month inside {[1:12]}) ||
                  (in_day == '0);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign step_req.dir   = dir_q;
  assign step_req.year  = year_q;
  assign step_req.month = month_q;
  assign step_req.day   = day_q;
  assign step_req.rem   = rem_q;
  assign step_req.r400  = r400_q;

  gdate_step u_step (
    .req_i (step_req),
    .rsp_o (step_rsp)
  );

  always_comb begin
    state_d  = state_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    rem_d    = rem_q;
    r400_d   = r400_q;
    yrem_d   = yrem_q;
    status_d = status_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          year_d  = in_year;
          month_d = in_month;
          day_d   = in_day;
          rem_d   = in_count_ext[CB-1:0];
          yrem_d  = in_year;
          if (in_bad) begin
            status_d = gdate_pkg::STATUS_INVALID;
            state_d  = ST_OUT;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (yrem_q >= gdate_pkg::CYCLE_400) begin
          yrem_d = yrem_q - gdate_pkg::CYCLE_400;
        end else begin
          r400_d  = yrem_q[gdate_pkg::R400_W-1:0];
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (day_q > gdate_pkg::month_len(month_q, gdate_pkg::leap_of(r400_q))) begin
          status_d = gdate_pkg::STATUS_INVALID;
          state_d  = ST_OUT;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (step_rsp.ovf) begin
          status_d = gdate_pkg::STATUS_RANGE;
          state_d  = ST_OUT;
        end else begin
          year_d  = step_rsp.year;
          month_d = step_rsp.month;
          day_d   = step_rsp.day;
          rem_d   = step_rsp.rem;
          r400_d  = step_rsp.r400;
          if (step_rsp.done) begin
            status_d = gdate_pkg::STATUS_OK;
            state_d  = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dir_q <= s_axis_tuser_i;
    end
    year_q   <= year_d;
    month_q  <= month_d;
    day_q    <= day_d;
    rem_q    <= rem_d;
    r400_q   <= r400_d;
    yrem_q   <= yrem_d;
    status_q <= status_d;
  end

  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = (status_q == gdate_pkg::STATUS_OK) ?
                           {1'b0, day_q, month_q, year_q} : '0;

  // no new request while a result is pending
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("request taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready right after a request");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != gdate_pkg::STATUS_OK) |-> (m_axis_tdata_o == '0))
    else $error("nonzero date with error status");

  a_ok_date_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == gdate_pkg::STATUS_OK) |->
      (m_axis_tdata_o[17:14] != '0 && m_axis_tdata_o[17:14] <= gdate_pkg::MONTH_DEC &&
       m_axis_tdata_o[22:18] != '0 && m_axis_tdata_o[13:0] != '0 &&
       m_axis_tdata_o[13:0] <= gdate_pkg::YEAR_MAX))
    else $error("ok result with bad date");

endmodule
